>>> rtl/kbd_sc_pkg.sv
// ----------------------------------------------------------------------------
// kbd_sc_pkg
// Types, key codes and translation tables for the scan code set 1 translator.
// ----------------------------------------------------------------------------
package kbd_sc_pkg;

	localparam int unsigned IN_W   = 8;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned LED_W  = 3;
	localparam int unsigned OUT_W  = 16;
	localparam int unsigned KEYS   = 96;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [6:0] LAST_KEY    = 7'h5F;
	localparam logic [6:0] K_SHIFT_L   = 7'h2A;
	localparam logic [6:0] K_SHIFT_R   = 7'h36;
	localparam logic [6:0] K_SLASH     = 7'h35;
	localparam logic [6:0] K_CAPS      = 7'h3A;
	localparam logic [6:0] K_NUM       = 7'h45;
	localparam logic [6:0] K_SCROLL    = 7'h46;
	localparam logic [6:0] CH_LOWER_A  = 7'h61;
	localparam logic [6:0] CH_LOWER_Z  = 7'h7A;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_LED  = 1'b1;

	typedef struct packed {
		logic prefix_seen;
		logic caps_on;
		logic num_on;
		logic scroll_on;
		logic shift_left_down;
		logic shift_right_down;
	} kbd_state_t;

	localparam logic [CHAR_W-1:0] PLAIN_COL [0:KEYS-1] = '{
		7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [CHAR_W-1:0] SHIFT_COL [0:KEYS-1] = '{
		7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
		7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2d, 7'h00, 7'h00, 7'h00, 7'h2b, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h7f, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage

>>> rtl/keyboard_scancode_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_to_ascii_unit
// Scan code set 1 byte stream to ASCII characters and LED settings.
// ----------------------------------------------------------------------------
// Path: an accepted byte is registered in stage 1 and translated there; its
// result is then registered in the output stage, which drives m_tvalid.
// Throughput: one byte per cycle while the output is not stalled; the
// one-entry state memory is read at accept and written back as the byte leaves stage 1, with forwarding.
// Reset: arst_n clears pipeline valids and the memory's valid bit, so the
// state reads as all zero until the first write-back.
// ----------------------------------------------------------------------------
module keyboard_scancode_to_ascii_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [kbd_sc_pkg::IN_W-1:0]       s_tdata,  // [7:0] scan_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic                              m_tuser,  // [0] result_kind
	output logic [kbd_sc_pkg::OUT_W-1:0]      m_tdata   // [6:0] char_code,
	                                                    // [9:7] led_bits
);

	kbd_sc_pkg::kbd_state_t state_mem [0:0];
	logic                   mem_vld_q;

	logic                          vld_s1;
	logic [kbd_sc_pkg::IN_W-1:0]   byte_s1;
	kbd_sc_pkg::kbd_state_t        st_s1;

	logic                          out_vld_q;
	logic                          kind_q;
	logic [kbd_sc_pkg::CHAR_W-1:0] char_q;
	logic [kbd_sc_pkg::LED_W-1:0]  led_q;

	kbd_sc_pkg::kbd_state_t        st_next;
	logic                          res_vld;
	logic                          res_kind;
	logic [kbd_sc_pkg::CHAR_W-1:0] res_char;
	logic [kbd_sc_pkg::LED_W-1:0]  res_led;
	logic                          out_free;
	logic                          adv_s1;
	logic                          acc_in;

	logic                          ext;
	logic [6:0]                    key;
	logic [kbd_sc_pkg::CHAR_W-1:0] plain_ch;
	logic [kbd_sc_pkg::CHAR_W-1:0] shift_ch;
	logic                          shift;

	assign out_free = !out_vld_q || m_tready;
	assign adv_s1   = vld_s1 && (!res_vld || out_free);
	assign s_tready = !vld_s1 || adv_s1;
	assign acc_in   = s_tvalid && s_tready;

	// translate the byte in stage 1 against the state read for it
	always_comb begin
		st_next  = st_s1;
		res_vld  = 1'b0;
		res_kind = kbd_sc_pkg::KIND_CHAR;
		res_char = '0;
		res_led  = '0;
		ext      = st_s1.prefix_seen;
		key      = byte_s1[6:0];
		plain_ch = '0;
		shift_ch = '0;
		shift    = 1'b0;
		if (key <= kbd_sc_pkg::LAST_KEY) begin
			plain_ch = kbd_sc_pkg::PLAIN_COL[key];
			shift_ch = kbd_sc_pkg::SHIFT_COL[key];
		end
		if (byte_s1 == kbd_sc_pkg::PREFIX_BYTE) begin
			st_next.prefix_seen = 1'b1;
		end else begin
			st_next.prefix_seen = 1'b0;
			if (key <= kbd_sc_pkg::LAST_KEY) begin
				if (byte_s1[7]) begin
					if (!ext && key == kbd_sc_pkg::K_SHIFT_L)
						st_next.shift_left_down = 1'b0;
					if (!ext && key == kbd_sc_pkg::K_SHIFT_R)
						st_next.shift_right_down = 1'b0;
				end else begin
					if (!ext && key == kbd_sc_pkg::K_SHIFT_L)
						st_next.shift_left_down = 1'b1;
					if (!ext && key == kbd_sc_pkg::K_SHIFT_R)
						st_next.shift_right_down = 1'b1;
					if (key == kbd_sc_pkg::K_NUM || key == kbd_sc_pkg::K_CAPS ||
					    key == kbd_sc_pkg::K_SCROLL) begin
						if (key == kbd_sc_pkg::K_NUM)
							st_next.num_on = !st_s1.num_on;
						if (key == kbd_sc_pkg::K_CAPS)
							st_next.caps_on = !st_s1.caps_on;
						if (key == kbd_sc_pkg::K_SCROLL)
							st_next.scroll_on = !st_s1.scroll_on;
						res_vld  = 1'b1;
						res_kind = kbd_sc_pkg::KIND_LED;
						res_led  = {st_next.caps_on, st_next.num_on, st_next.scroll_on};
					end else begin
						if (ext) begin
							res_char = (key == kbd_sc_pkg::K_SLASH) ? plain_ch : shift_ch;
						end else begin
							// caps flips shift for lower-case letters only
							shift = st_s1.caps_on && plain_ch >= kbd_sc_pkg::CH_LOWER_A &&
							        plain_ch <= kbd_sc_pkg::CH_LOWER_Z;
							if (st_s1.shift_left_down || st_s1.shift_right_down)
								shift = !shift;
							res_char = shift ? shift_ch : plain_ch;
						end
						res_vld = (res_char != '0);
					end
				end
			end
		end
	end

	// state memory: write back as stage 1 retires, read at accept
	always_ff @(posedge clk) begin
		if (adv_s1)
			state_mem[0] <= st_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= 1'b0;
		end else if (adv_s1) begin
			mem_vld_q <= 1'b1;
		end
	end

	// forward the write-back of the byte leaving stage 1 this cycle
	always_ff @(posedge clk) begin
		if (acc_in) begin
			byte_s1 <= s_tdata;
			if (adv_s1)
				st_s1 <= st_next;
			else if (mem_vld_q)
				st_s1 <= state_mem[0];
			else
				st_s1 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc_in)
				vld_s1 <= 1'b1;
			else if (adv_s1)
				vld_s1 <= 1'b0;
			if (adv_s1 && res_vld)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_vld) begin
			kind_q <= res_kind;
			char_q <= res_char;
			led_q  <= res_led;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {6'b0, led_q, char_q};

endmodule

>>> rtl/kbd_sc_checker.sv
// ----------------------------------------------------------------------------
// kbd_sc_checker
// Port-level checks on the scan code translator, bound to the top level.
// ----------------------------------------------------------------------------
module kbd_sc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic                         m_tuser,
	input logic [kbd_sc_pkg::OUT_W-1:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_led_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == kbd_sc_pkg::KIND_LED |-> m_tdata[6:0] == '0)
		else $error("LED result carries a character");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == kbd_sc_pkg::KIND_CHAR |->
		m_tdata[9:7] == '0 && m_tdata[6:0] != '0 && m_tdata[15:10] == '0)
		else $error("malformed character result");

	// a fresh result must trace back to an accepted byte
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without an accepted byte");

endmodule

bind keyboard_scancode_to_ascii_unit kbd_sc_checker u_kbd_sc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);

>>> tb/tb_keyboard_scancode_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// tb_keyboard_scancode_to_ascii_unit
// Streams scan code set 1 bytes into the translator: a directed opening with
// prefix, release, shift, lock and out-of-range keys, then random key
// sequences mixed with noise. A scoreboard class tracks keyboard state,
// predicts each character or LED transfer and compares it field by field.
// Both stream sides idle at random except near the end of the run.
// ----------------------------------------------------------------------------
module tb_keyboard_scancode_to_ascii_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned N_RANDOM    = 800;
	localparam int unsigned N_QUIET     = 100;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 10;

	localparam bit [7:0] BYTE_PREFIX = 8'hE0;
	localparam bit [7:0] BYTE_BREAK  = 8'h80;
	localparam bit [6:0] KEY_TOP     = 7'h5F;
	localparam bit [6:0] KEY_LSHIFT  = 7'h2A;
	localparam bit [6:0] KEY_RSHIFT  = 7'h36;
	localparam bit [6:0] KEY_DIV     = 7'h35;
	localparam bit [6:0] KEY_CAPS    = 7'h3A;
	localparam bit [6:0] KEY_NUM     = 7'h45;
	localparam bit [6:0] KEY_SCROLL  = 7'h46;
	localparam bit [6:0] KEY_A       = 7'h1E;
	localparam bit [6:0] KEY_CTRL    = 7'h1D;
	localparam bit [6:0] KEY_DEL     = 7'h53;
	localparam bit [6:0] ASCII_LOW_A = 7'h61;
	localparam bit [6:0] ASCII_LOW_Z = 7'h7A;

	localparam bit [6:0] UNSHIFTED_TAB [0:95] = '{
		7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam bit [6:0] SHIFTED_TAB [0:95] = '{
		7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
		7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2d, 7'h00, 7'h00, 7'h00, 7'h2b, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h7f, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef struct packed {
		bit       result_kind;
		bit [5:0] pad;
		bit [2:0] led_bits;
		bit [6:0] char_code;
	} key_result_t;

	class keystroke_tracker;
		bit          after_prefix;
		bit          caps_lock;
		bit          num_lock;
		bit          scroll_lock;
		bit          lshift_held;
		bit          rshift_held;
		key_result_t pending_results[$];
		int unsigned mismatches;

		function void take_byte(bit [7:0] scan);
			bit          extended;
			bit [6:0]    key;
			bit [6:0]    ch;
			bit          shifted;
			key_result_t res;
			if (scan == BYTE_PREFIX) begin
				after_prefix = 1'b1;
				return;
			end
			extended     = after_prefix;
			after_prefix = 1'b0;
			key          = scan[6:0];
			if (key > KEY_TOP)
				return;
			if ((scan & BYTE_BREAK) != 8'h00) begin
				if (!extended) begin
					if (key == KEY_LSHIFT)
						lshift_held = 1'b0;
					else if (key == KEY_RSHIFT)
						rshift_held = 1'b0;
				end
				return;
			end
			if (!extended) begin
				if (key == KEY_LSHIFT)
					lshift_held = 1'b1;
				else if (key == KEY_RSHIFT)
					rshift_held = 1'b1;
			end
			res = '0;
			if (key == KEY_NUM || key == KEY_CAPS || key == KEY_SCROLL) begin
				if (key == KEY_NUM)
					num_lock = !num_lock;
				else if (key == KEY_CAPS)
					caps_lock = !caps_lock;
				else
					scroll_lock = !scroll_lock;
				res.result_kind = kbd_sc_pkg::KIND_LED;
				res.led_bits    = {caps_lock, num_lock, scroll_lock};
				pending_results.push_back(res);
				return;
			end
			if (extended) begin
				ch = (key == KEY_DIV) ? UNSHIFTED_TAB[key] : SHIFTED_TAB[key];
			end else begin
				// caps only flips letters; a held shift flips again
				shifted = caps_lock && UNSHIFTED_TAB[key] >= ASCII_LOW_A &&
					UNSHIFTED_TAB[key] <= ASCII_LOW_Z;
				if (lshift_held || rshift_held)
					shifted = !shifted;
				ch = shifted ? SHIFTED_TAB[key] : UNSHIFTED_TAB[key];
			end
			if (ch == 7'h00)
				return;
			res.result_kind = kbd_sc_pkg::KIND_CHAR;
			res.char_code   = ch;
			pending_results.push_back(res);
		endfunction

		function void check_output(key_result_t got);
			key_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected output: kind=%0d char=%h led=%b",
						$realtime, got.result_kind, got.char_code, got.led_bits);
				return;
			end
			want = pending_results.pop_front();
			if (got.result_kind != want.result_kind || got.char_code != want.char_code ||
					got.led_bits != want.led_bits) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"[%0t] mismatch: expected kind=%0d char=%h led=%b,",
						" got kind=%0d char=%h led=%b"},
						$realtime, want.result_kind, want.char_code, want.led_bits,
						got.result_kind, got.char_code, got.led_bits);
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [kbd_sc_pkg::IN_W-1:0]     s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic                            m_tuser;
	logic [kbd_sc_pkg::OUT_W-1:0]    m_tdata;

	keystroke_tracker tracker = new();
	bit               quiet_phase;
	bit               sender_may_idle;
	int unsigned      bytes_sent;
	int unsigned      cycle_count = 0;

	keyboard_scancode_to_ascii_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// note inputs before checking outputs so a same-edge result finds its expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.take_byte(s_tdata);
			if (m_tvalid && m_tready)
				tracker.check_output(key_result_t'({m_tuser, m_tdata}));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (quiet_phase || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input bit [7:0] scan);
		if (!quiet_phase && sender_may_idle && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= scan;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic tap_key(input bit [6:0] key, input bit extended);
		if (extended)
			send_byte(BYTE_PREFIX);
		send_byte({1'b0, key});
		if ($urandom_range(0, 1)) begin
			if (extended)
				send_byte(BYTE_PREFIX);
			send_byte({1'b1, key});
		end
	endtask

	// let the monitor note the last transfer before looking at the queue
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		bit [7:0]    opening[$];
		bit [6:0]    shift_key;
		int unsigned n_opening;
		int unsigned pick;
		arst_n          <= 1'b0;
		s_tvalid        <= 1'b0;
		s_tdata         <= '0;
		bytes_sent      = 0;
		quiet_phase     = 1'b0;
		sender_may_idle = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		opening = '{8'h00, 8'hFF, 8'h60, 8'h7F,
			BYTE_PREFIX, BYTE_PREFIX, 8'h70,             // double prefix, then dropped key
			{1'b0, KEY_A}, {1'b0, KEY_CAPS}, {1'b0, KEY_A}, 8'h02,
			{1'b0, KEY_LSHIFT}, {1'b0, KEY_A}, {1'b1, KEY_LSHIFT},
			{1'b0, KEY_RSHIFT}, 8'h02, {1'b1, KEY_RSHIFT},
			BYTE_PREFIX, {1'b0, KEY_LSHIFT}, {1'b0, KEY_A},  // extended shift holds nothing
			BYTE_PREFIX, {1'b0, KEY_DIV}, BYTE_PREFIX, {1'b0, KEY_DEL},
			{1'b0, KEY_NUM}, {1'b0, KEY_SCROLL}, BYTE_PREFIX, {1'b0, KEY_CAPS},
			{1'b0, KEY_CTRL}, BYTE_PREFIX, {1'b1, KEY_LSHIFT}};
		foreach (opening[i])
			send_byte(opening[i]);
		n_opening = bytes_sent;

		// hold the sender until the opening has fully drained
		wait_drained();
		repeat (4) @(posedge clk);

		while (bytes_sent < n_opening + N_RANDOM) begin
			quiet_phase     = (bytes_sent >= n_opening + N_RANDOM - N_QUIET);
			sender_may_idle = ($urandom_range(0, 2) != 0);
			pick            = $urandom_range(0, 99);
			if (pick < 10) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 22) begin
				shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
				send_byte({1'b0, shift_key});
				repeat ($urandom_range(1, 4))
					tap_key(7'($urandom_range(0, KEY_TOP)), 1'b0);
				send_byte({1'b1, shift_key});
			end else if (pick < 30) begin
				case ($urandom_range(0, 2))
					0: tap_key(KEY_CAPS, $urandom_range(0, 3) == 0);
					1: tap_key(KEY_NUM, $urandom_range(0, 3) == 0);
					default: tap_key(KEY_SCROLL, $urandom_range(0, 3) == 0);
				endcase
			end else if (pick < 42) begin
				tap_key(7'($urandom_range(0, KEY_TOP)), 1'b1);
			end else if (pick < 47) begin
				// broken sequences: dangling prefix or stray release
				if ($urandom_range(0, 1))
					send_byte(BYTE_PREFIX);
				else
					send_byte({1'b1, 7'($urandom_range(0, 127))});
			end else begin
				tap_key(7'($urandom_range(0, KEY_TOP)), 1'b0);
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> keyboard_scancode_to_ascii_unit.f
rtl/kbd_sc_pkg.sv
rtl/keyboard_scancode_to_ascii_unit.sv
rtl/kbd_sc_checker.sv
tb/tb_keyboard_scancode_to_ascii_unit.sv
